// File: hw/rtl/pev_pkg.sv
// pev_pkg: shared types, sizes and codes of the packing excluded-volume finder
// depends on nothing; every rtl file of the block refers to it by scoped names

package pev_pkg;

   localparam int MAX_BOXES  = 64;
   localparam int COORD_BITS = 10;
   localparam int IDX_BITS   = $clog2(MAX_BOXES);
   localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
   localparam int SUM_BITS   = COORD_BITS + 1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   // item operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // spawn side of a query point
   localparam logic [1:0] KIND_RIGHT = 2'd0;
   localparam logic [1:0] KIND_TOP   = 2'd1;
   localparam logic [1:0] KIND_FRONT = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type z0;
      coord_type xl;
      coord_type yl;
      coord_type zl;
   } box_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // neighbour roles hit by one box, or held over a whole scan
   typedef struct packed {
      logic left;
      logic behind;
      logic below;
   } hits_type;

   function automatic sum_type ext(input coord_type c);
      return {1'b0, c};
   endfunction

endpackage

// File: hw/rtl/pev_box_store.sv
// pev_box_store: memory of placed boxes, one write port and one registered read port
// depends on pev_pkg for the box record and index width

module pev_box_store (
   input  logic             clock,
   input  logic             wr_en,
   input  pev_pkg::idx_type wr_addr,
   input  pev_pkg::box_type wr_data,
   input  logic             rd_en,
   input  pev_pkg::idx_type rd_addr,
   output pev_pkg::box_type rd_data
);

   pev_pkg::box_type mem [pev_pkg::MAX_BOXES];
   pev_pkg::box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pev_match_unit.sv
// pev_match_unit: compares one stored box against the query point for all three roles
// depends on pev_pkg for box, point and hit types

module pev_match_unit (
   input  pev_pkg::box_type   box,
   input  pev_pkg::point_type point,
   input  logic [1:0]         kind,
   output pev_pkg::hits_type  hits
);

   function automatic logic in_span(input pev_pkg::coord_type lo,
                                    input pev_pkg::coord_type len,
                                    input pev_pkg::coord_type v);
      return (pev_pkg::ext(lo) <= pev_pkg::ext(v)) &&
             (pev_pkg::ext(v) < pev_pkg::ext(lo) + pev_pkg::ext(len));
   endfunction

   logic left_face, behind_face, below_face;
   logic left_exact, behind_exact, below_exact;
   logic left_cont, behind_cont, below_cont;
   logic in_x, in_y, in_z;

   always_comb begin
      left_face   = (pev_pkg::ext(box.x0) + pev_pkg::ext(box.xl)) == pev_pkg::ext(point.x);
      behind_face = (pev_pkg::ext(box.z0) + pev_pkg::ext(box.zl)) == pev_pkg::ext(point.z);
      below_face  = (pev_pkg::ext(box.y0) + pev_pkg::ext(box.yl)) == pev_pkg::ext(point.y);

      in_x = in_span(box.x0, box.xl, point.x);
      in_y = in_span(box.y0, box.yl, point.y);
      in_z = in_span(box.z0, box.zl, point.z);

      left_exact   = left_face && (box.y0 == point.y) && (box.z0 == point.z);
      behind_exact = behind_face && (box.x0 == point.x) && (box.y0 == point.y);
      below_exact  = below_face && (box.x0 == point.x) && (box.z0 == point.z);

      left_cont   = left_face && in_y && in_z;
      behind_cont = behind_face && in_y && in_x;
      below_cont  = below_face && in_z && in_x;

      // the role the point spawned from needs an exact corner match
      hits.left   = (kind == pev_pkg::KIND_RIGHT) ? left_exact   : left_cont;
      hits.behind = (kind == pev_pkg::KIND_FRONT) ? behind_exact : behind_cont;
      hits.below  = (kind == pev_pkg::KIND_TOP)   ? below_exact  : below_cont;
   end

endmodule

// File: hw/rtl/pev_volume_calc.sv
// pev_volume_calc: derives the excluded box lengths from the neighbours kept by a scan
// depends on pev_pkg for box, point and hit types

module pev_volume_calc (
   input  logic [1:0]          kind,
   input  pev_pkg::point_type  point,
   input  pev_pkg::coord_type  free_width,
   input  pev_pkg::coord_type  free_height,
   input  pev_pkg::coord_type  free_depth,
   input  pev_pkg::hits_type   hits,
   input  pev_pkg::box_type    lf,
   input  pev_pkg::box_type    bh,
   input  pev_pkg::box_type    bl,
   output logic                found,
   output pev_pkg::coord_type  len_x,
   output pev_pkg::coord_type  len_y,
   output pev_pkg::coord_type  len_z
);

   function automatic pev_pkg::sum_type umin(input pev_pkg::sum_type a,
                                             input pev_pkg::sum_type b);
      return (a < b) ? a : b;
   endfunction

   // far face of a neighbour minus the point, never negative for a matched box
   function automatic pev_pkg::sum_type reach(input pev_pkg::coord_type lo,
                                              input pev_pkg::coord_type len,
                                              input pev_pkg::coord_type p);
      return pev_pkg::ext(lo) + pev_pkg::ext(len) - pev_pkg::ext(p);
   endfunction

   pev_pkg::sum_type bh_dx, bh_dy, bl_dx, bl_dz, lf_dy, lf_dz;
   pev_pkg::sum_type x, y, z;
   logic ok;

   always_comb begin
      bh_dx = reach(bh.x0, bh.xl, point.x);
      bh_dy = reach(bh.y0, bh.yl, point.y);
      bl_dx = reach(bl.x0, bl.xl, point.x);
      bl_dz = reach(bl.z0, bl.zl, point.z);
      lf_dy = reach(lf.y0, lf.yl, point.y);
      lf_dz = reach(lf.z0, lf.zl, point.z);

      ok = 1'b0;
      x  = '0;
      y  = '0;
      z  = '0;

      case (kind)
         pev_pkg::KIND_RIGHT: begin
            ok = hits.left && (hits.behind || (point.z == '0));
            z  = pev_pkg::ext(lf.zl);
            if (hits.below) begin
               z = umin(z, bl_dz);
            end
            x = hits.behind ? bh_dx : pev_pkg::ext(free_width);
            if (hits.below) begin
               x = umin(x, bl_dx);
            end
            y = hits.behind ? umin(pev_pkg::ext(bh.yl), pev_pkg::ext(lf.yl))
                            : pev_pkg::ext(lf.yl);
         end
         pev_pkg::KIND_TOP: begin
            // a top point needs its supporting box
            ok = hits.below && (hits.behind || (point.z == '0)) &&
                 (hits.left || (point.x == '0));
            x  = hits.behind ? umin(pev_pkg::ext(bl.xl), bh_dx) : pev_pkg::ext(bl.xl);
            z  = hits.left ? umin(pev_pkg::ext(bl.zl), lf_dz) : pev_pkg::ext(bl.zl);
            if (hits.behind && hits.left) begin
               y = umin(bh_dy, lf_dy);
            end else if (hits.left) begin
               y = lf_dy;
            end else if (hits.behind) begin
               y = bh_dy;
            end else begin
               y = pev_pkg::ext(free_height);
            end
         end
         pev_pkg::KIND_FRONT: begin
            ok = hits.behind && (hits.left || (point.x == '0));
            x  = pev_pkg::ext(bh.xl);
            if (hits.below) begin
               x = umin(x, bl_dx);
            end
            z = hits.left ? lf_dz : pev_pkg::ext(free_depth);
            if (hits.below) begin
               z = umin(z, bl_dz);
            end
            y = hits.left ? umin(pev_pkg::ext(bh.yl), pev_pkg::ext(lf.yl))
                          : pev_pkg::ext(bh.yl);
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      found = ok && (x != '0) && (y != '0) && (z != '0);
      len_x = found ? x[pev_pkg::COORD_BITS-1:0] : '0;
      len_y = found ? y[pev_pkg::COORD_BITS-1:0] : '0;
      len_z = found ? z[pev_pkg::COORD_BITS-1:0] : '0;
   end

endmodule

// File: hw/rtl/packing_excluded_volume_finder.sv
// packing_excluded_volume_finder: top level with the scan sequencer and result register
// depends on pev_pkg, pev_box_store, pev_match_unit and pev_volume_calc
//
// Usage:
//   The req_ channel carries one item per accepted valid/stall handshake. A clear
//   item empties the box store and an append item stores one box (ignored when the
//   store is full); both finish in the cycle they are accepted and give no result.
//   An op code of three is dropped the same way. A query item gives exactly one
//   item on the rsp_ channel: found plus the three lengths, or zeros when no
//   excluded box exists.
//   A query reads the store through its single read port, one box a cycle, and
//   holds req_stall high while it scans, drains the read port and computes the
//   result; on an empty store it skips the scan and the drain. Clear and append
//   items never raise req_stall and may follow each other back to back.
//   The result sits in an output register; while rsp_stall is high it holds, and
//   a query finishing meanwhile waits with req_stall high until the register frees.
//   Reset (synchronous, active high) empties the store and drops any pending
//   result; the box memory itself is not cleared.

module packing_excluded_volume_finder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  pev_pkg::coord_type  req_pos_x,
   input  pev_pkg::coord_type  req_pos_y,
   input  pev_pkg::coord_type  req_pos_z,
   input  pev_pkg::coord_type  req_len_x,
   input  pev_pkg::coord_type  req_len_y,
   input  pev_pkg::coord_type  req_len_z,
   input  logic [1:0]          req_kind,
   input  pev_pkg::coord_type  req_free_width,
   input  pev_pkg::coord_type  req_free_height,
   input  pev_pkg::coord_type  req_free_depth,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output pev_pkg::coord_type  rsp_out_len_x,
   output pev_pkg::coord_type  rsp_out_len_y,
   output pev_pkg::coord_type  rsp_out_len_z
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CALC
   } state_type;

   state_type          state_ff;
   pev_pkg::cnt_type   count_ff;
   pev_pkg::idx_type   idx_ff;
   logic               rd_valid_ff;
   pev_pkg::point_type point_ff;
   logic [1:0]         kind_ff;
   pev_pkg::coord_type free_width_ff, free_height_ff, free_depth_ff;
   pev_pkg::hits_type  hits_ff;
   pev_pkg::box_type   lf_ff, bh_ff, bl_ff;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   pev_pkg::coord_type rsp_len_x_ff, rsp_len_y_ff, rsp_len_z_ff;

   logic               accept;
   logic               wr_en;
   pev_pkg::box_type   wr_data;
   logic               rd_en;
   pev_pkg::box_type   rd_data;
   pev_pkg::hits_type  box_hits;
   logic               last_issue;
   logic               rsp_free;
   logic               rsp_load;
   logic               calc_found;
   pev_pkg::coord_type calc_len_x, calc_len_y, calc_len_z;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign wr_en      = accept && (req_op == pev_pkg::OP_APPEND) &&
                       (count_ff < pev_pkg::CNT_BITS'(pev_pkg::MAX_BOXES));
   assign wr_data    = '{x0: req_pos_x, y0: req_pos_y, z0: req_pos_z,
                         xl: req_len_x, yl: req_len_y, zl: req_len_z};
   assign rd_en      = (state_ff == ST_SCAN);
   assign last_issue = (pev_pkg::CNT_BITS'(idx_ff) + pev_pkg::CNT_BITS'(1)) == count_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == ST_CALC) && rsp_free;

   pev_box_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[pev_pkg::IDX_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   pev_match_unit u_match (
      .box   (rd_data),
      .point (point_ff),
      .kind  (kind_ff),
      .hits  (box_hits)
   );

   pev_volume_calc u_calc (
      .kind        (kind_ff),
      .point       (point_ff),
      .free_width  (free_width_ff),
      .free_height (free_height_ff),
      .free_depth  (free_depth_ff),
      .hits        (hits_ff),
      .lf          (lf_ff),
      .bh          (bh_ff),
      .bl          (bl_ff),
      .found       (calc_found),
      .len_x       (calc_len_x),
      .len_y       (calc_len_y),
      .len_z       (calc_len_z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_found_ff <= calc_found;
            rsp_len_x_ff <= calc_len_x;
            rsp_len_y_ff <= calc_len_y;
            rsp_len_z_ff <= calc_len_z;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // later boxes overwrite earlier ones, so each role keeps its last match
         if (rd_valid_ff) begin
            if (box_hits.left) begin
               hits_ff.left <= 1'b1;
               lf_ff        <= rd_data;
            end
            if (box_hits.behind) begin
               hits_ff.behind <= 1'b1;
               bh_ff          <= rd_data;
            end
            if (box_hits.below) begin
               hits_ff.below <= 1'b1;
               bl_ff         <= rd_data;
            end
         end

         if (wr_en) begin
            count_ff <= count_ff + pev_pkg::CNT_BITS'(1);
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_op == pev_pkg::OP_CLEAR) begin
                     count_ff <= '0;
                  end else if (req_op == pev_pkg::OP_QUERY) begin
                     point_ff       <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
                     kind_ff        <= req_kind;
                     free_width_ff  <= req_free_width;
                     free_height_ff <= req_free_height;
                     free_depth_ff  <= req_free_depth;
                     hits_ff        <= '0;
                     idx_ff         <= '0;
                     state_ff       <= (count_ff == '0) ? ST_CALC : ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (last_issue) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  idx_ff <= idx_ff + pev_pkg::IDX_BITS'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_out_len_x = rsp_len_x_ff;
   assign rsp_out_len_y = rsp_len_y_ff;
   assign rsp_out_len_z = rsp_len_z_ff;

   // a query keeps the input side busy for at least the following cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == pev_pkg::OP_QUERY) |=> req_stall)
      else $error("query accepted without holding off the next item");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pev_pkg::CNT_BITS'(pev_pkg::MAX_BOXES))
      else $error("box count beyond store depth");

   // read data is only consumed while a scan is running or draining
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN) || (state_ff == ST_DRAIN))
      else $error("store read data outside a scan");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(state_ff) == ST_CALC)
      else $error("result raised without a finished query");

endmodule

// File: verif/tb.sv
// tb: self-checking bench for packing_excluded_volume_finder (box store, extreme-point query)
// depends on pev_pkg and the rtl of the block; a scoreboard class predicts each query result

`timescale 1ns / 100ps

module tb;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [1:0]         op;
      pev_pkg::coord_type pos_x;
      pev_pkg::coord_type pos_y;
      pev_pkg::coord_type pos_z;
      pev_pkg::coord_type len_x;
      pev_pkg::coord_type len_y;
      pev_pkg::coord_type len_z;
      logic [1:0]         kind;
      pev_pkg::coord_type free_width;
      pev_pkg::coord_type free_height;
      pev_pkg::coord_type free_depth;
   } req_item_type;

   typedef struct packed {
      logic               found;
      pev_pkg::coord_type len_x;
      pev_pkg::coord_type len_y;
      pev_pkg::coord_type len_z;
   } volume_type;

   class volume_scoreboard;
      pev_pkg::box_type stored[pev_pkg::MAX_BOXES];
      int unsigned      stored_count;
      volume_type       pending_volumes[$];
      int               errors;

      function new();
         stored_count = 0;
         errors = 0;
      endfunction

      function pev_pkg::sum_type far_edge(pev_pkg::coord_type lo, pev_pkg::coord_type len);
         return pev_pkg::ext(lo) + pev_pkg::ext(len);
      endfunction

      function logic covers(pev_pkg::coord_type lo, pev_pkg::coord_type len,
                            pev_pkg::coord_type v);
         return lo <= v && pev_pkg::ext(v) < far_edge(lo, len);
      endfunction

      function pev_pkg::sum_type shortest(pev_pkg::sum_type a, pev_pkg::sum_type b);
         return a < b ? a : b;
      endfunction

      // scan every stored box, keep the last match per role, then size the excluded box
      function volume_type excluded_volume(req_item_type it);
         pev_pkg::box_type lf, bh, bl, b;
         logic             hl, hb, hd, ml, mb, md, ok;
         pev_pkg::sum_type x, y, z, px, py, pz;
         volume_type       v;
         int               i;
         lf = '0; bh = '0; bl = '0;
         hl = 1'b0; hb = 1'b0; hd = 1'b0; ok = 1'b0;
         x = '0; y = '0; z = '0;
         px = pev_pkg::ext(it.pos_x);
         py = pev_pkg::ext(it.pos_y);
         pz = pev_pkg::ext(it.pos_z);
         for (i = 0; i < stored_count; i++) begin
            b = stored[i];
            if (it.kind == pev_pkg::KIND_RIGHT)
               ml = far_edge(b.x0, b.xl) == px && b.y0 == it.pos_y && b.z0 == it.pos_z;
            else
               ml = far_edge(b.x0, b.xl) == px && covers(b.y0, b.yl, it.pos_y)
                    && covers(b.z0, b.zl, it.pos_z);
            if (it.kind == pev_pkg::KIND_FRONT)
               mb = far_edge(b.z0, b.zl) == pz && b.x0 == it.pos_x && b.y0 == it.pos_y;
            else
               mb = far_edge(b.z0, b.zl) == pz && covers(b.y0, b.yl, it.pos_y)
                    && covers(b.x0, b.xl, it.pos_x);
            if (it.kind == pev_pkg::KIND_TOP)
               md = far_edge(b.y0, b.yl) == py && b.x0 == it.pos_x && b.z0 == it.pos_z;
            else
               md = far_edge(b.y0, b.yl) == py && covers(b.z0, b.zl, it.pos_z)
                    && covers(b.x0, b.xl, it.pos_x);
            if (ml) begin lf = b; hl = 1'b1; end
            if (mb) begin bh = b; hb = 1'b1; end
            if (md) begin bl = b; hd = 1'b1; end
         end
         case (it.kind)
            pev_pkg::KIND_RIGHT: begin
               if (hl && (hb || pz == 0)) begin
                  z = pev_pkg::ext(lf.zl);
                  if (hd) z = shortest(z, far_edge(bl.z0, bl.zl) - pz);
                  x = hb ? far_edge(bh.x0, bh.xl) - px : pev_pkg::ext(it.free_width);
                  if (hd) x = shortest(x, far_edge(bl.x0, bl.xl) - px);
                  y = hb ? shortest(pev_pkg::ext(bh.yl), pev_pkg::ext(lf.yl))
                         : pev_pkg::ext(lf.yl);
                  ok = 1'b1;
               end
            end
            pev_pkg::KIND_TOP: begin
               if (hd && (hb || pz == 0) && (hl || px == 0)) begin
                  x = hb ? shortest(pev_pkg::ext(bl.xl), far_edge(bh.x0, bh.xl) - px)
                         : pev_pkg::ext(bl.xl);
                  z = hl ? shortest(pev_pkg::ext(bl.zl), far_edge(lf.z0, lf.zl) - pz)
                         : pev_pkg::ext(bl.zl);
                  if (hb && hl)
                     y = shortest(far_edge(bh.y0, bh.yl) - py, far_edge(lf.y0, lf.yl) - py);
                  else if (hl)
                     y = far_edge(lf.y0, lf.yl) - py;
                  else if (hb)
                     y = far_edge(bh.y0, bh.yl) - py;
                  else
                     y = pev_pkg::ext(it.free_height);
                  ok = 1'b1;
               end
            end
            pev_pkg::KIND_FRONT: begin
               if (hb && (hl || px == 0)) begin
                  x = pev_pkg::ext(bh.xl);
                  if (hd) x = shortest(x, far_edge(bl.x0, bl.xl) - px);
                  z = hl ? far_edge(lf.z0, lf.zl) - pz : pev_pkg::ext(it.free_depth);
                  if (hd) z = shortest(z, far_edge(bl.z0, bl.zl) - pz);
                  y = hl ? shortest(pev_pkg::ext(bh.yl), pev_pkg::ext(lf.yl))
                         : pev_pkg::ext(bh.yl);
                  ok = 1'b1;
               end
            end
            default: ok = 1'b0;
         endcase
         if (!ok || x == 0 || y == 0 || z == 0) begin
            v = '0;
         end else begin
            v.found = 1'b1;
            v.len_x = x[pev_pkg::COORD_BITS-1:0];
            v.len_y = y[pev_pkg::COORD_BITS-1:0];
            v.len_z = z[pev_pkg::COORD_BITS-1:0];
         end
         return v;
      endfunction

      function void note_item(req_item_type it);
         case (it.op)
            pev_pkg::OP_CLEAR:  stored_count = 0;
            pev_pkg::OP_APPEND: begin
               // a full store drops the box
               if (stored_count < pev_pkg::MAX_BOXES) begin
                  stored[stored_count] = '{it.pos_x, it.pos_y, it.pos_z,
                                           it.len_x, it.len_y, it.len_z};
                  stored_count++;
               end
            end
            pev_pkg::OP_QUERY:  pending_volumes.push_back(excluded_volume(it));
            default:   ;
         endcase
      endfunction

      task report(string msg);
         $display("[%0t] error: %s", $time, msg);
         errors++;
      endtask

      task check_result(volume_type got);
         volume_type want;
         if (pending_volumes.size() == 0) begin
            report($sformatf("result with no query waiting: found=%0d len=%0d/%0d/%0d",
                             got.found, got.len_x, got.len_y, got.len_z));
            return;
         end
         want = pending_volumes.pop_front();
         if (got.found !== want.found)
            report($sformatf("found %0d, predicted %0d", got.found, want.found));
         if (got.len_x !== want.len_x)
            report($sformatf("out_len_x %0d, predicted %0d", got.len_x, want.len_x));
         if (got.len_y !== want.len_y)
            report($sformatf("out_len_y %0d, predicted %0d", got.len_y, want.len_y));
         if (got.len_z !== want.len_z)
            report($sformatf("out_len_z %0d, predicted %0d", got.len_z, want.len_z));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   pev_pkg::coord_type req_pos_x, req_pos_y, req_pos_z;
   pev_pkg::coord_type req_len_x, req_len_y, req_len_z;
   logic [1:0]         req_kind;
   pev_pkg::coord_type req_free_width, req_free_height, req_free_depth;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_found;
   pev_pkg::coord_type rsp_out_len_x, rsp_out_len_y, rsp_out_len_z;

   volume_scoreboard   sb = new();
   pev_pkg::box_type   placed[$];
   int                 items_sent;
   logic               sender_steady;
   int                 stall_left = 0;
   int                 idle_cycles = 0;

   packing_excluded_volume_finder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_len_x       (req_len_x),
      .req_len_y       (req_len_y),
      .req_len_z       (req_len_z),
      .req_kind        (req_kind),
      .req_free_width  (req_free_width),
      .req_free_height (req_free_height),
      .req_free_depth  (req_free_depth),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_out_len_x   (rsp_out_len_x),
      .rsp_out_len_y   (rsp_out_len_y),
      .rsp_out_len_z   (rsp_out_len_z)
   );

   always #5 clock = ~clock;

   function automatic req_item_type make_item(logic [1:0] op, pev_pkg::coord_type x,
                                              pev_pkg::coord_type y, pev_pkg::coord_type z,
                                              pev_pkg::coord_type lx, pev_pkg::coord_type ly,
                                              pev_pkg::coord_type lz, logic [1:0] kind,
                                              pev_pkg::coord_type fw, pev_pkg::coord_type fh,
                                              pev_pkg::coord_type fd);
      return '{op, x, y, z, lx, ly, lz, kind, fw, fh, fd};
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_steady) return 0;
      r = $urandom_range(0, 9);
      if (r < 5) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic pev_pkg::coord_type small_coord();
      return ($urandom_range(0, 2) == 0) ? pev_pkg::coord_type'(0)
                                         : pev_pkg::coord_type'($urandom_range(0, 12));
   endfunction

   function automatic pev_pkg::coord_type pick_len();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r < 3) return pev_pkg::coord_type'($urandom_range(0, 1023));
      return pev_pkg::coord_type'($urandom_range(1, 6));
   endfunction

   function automatic pev_pkg::coord_type free_len();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return pev_pkg::coord_type'($urandom_range(1, 8));
      return pev_pkg::coord_type'($urandom_range(0, 1023));
   endfunction

   function automatic pev_pkg::coord_type any_coord();
      return pev_pkg::coord_type'($urandom_range(0, 1023));
   endfunction

   // new boxes mostly sit on an extreme point of a placed box so that faces touch
   function automatic pev_pkg::box_type fresh_box();
      pev_pkg::box_type b, base;
      int               r;
      r = $urandom_range(0, 9);
      b.xl = pick_len();
      b.yl = pick_len();
      b.zl = pick_len();
      if (r == 0) begin
         b = '{any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord()};
      end else if (r < 3 || placed.size() == 0) begin
         b.x0 = small_coord();
         b.y0 = small_coord();
         b.z0 = small_coord();
      end else begin
         base = placed[$urandom_range(0, placed.size() - 1)];
         b.x0 = base.x0;
         b.y0 = base.y0;
         b.z0 = base.z0;
         case ($urandom_range(0, 2))
            0:       b.x0 = base.x0 + base.xl;
            1:       b.y0 = base.y0 + base.yl;
            default: b.z0 = base.z0 + base.zl;
         endcase
      end
      return b;
   endfunction

   function automatic req_item_type query_item();
      req_item_type     q;
      pev_pkg::box_type base;
      q = make_item(pev_pkg::OP_QUERY, small_coord(), small_coord(), small_coord(),
                    any_coord(), any_coord(), any_coord(), 2'($urandom_range(0, 3)),
                    free_len(), free_len(), free_len());
      if (placed.size() > 0 && $urandom_range(0, 3) != 0) begin
         base = placed[$urandom_range(0, placed.size() - 1)];
         q.kind = ($urandom_range(0, 9) == 0) ? pev_pkg::KIND_OTHER
                                              : 2'($urandom_range(0, 2));
         q.pos_x = base.x0;
         q.pos_y = base.y0;
         q.pos_z = base.z0;
         case (q.kind)
            pev_pkg::KIND_RIGHT: q.pos_x = base.x0 + base.xl;
            pev_pkg::KIND_TOP:   q.pos_y = base.y0 + base.yl;
            pev_pkg::KIND_FRONT: q.pos_z = base.z0 + base.zl;
            default:    ;
         endcase
         if ($urandom_range(0, 7) == 0) q.pos_x = '0;
         if ($urandom_range(0, 7) == 0) q.pos_z = '0;
      end else if ($urandom_range(0, 1) == 0) begin
         q.pos_x = any_coord();
         q.pos_y = any_coord();
         q.pos_z = any_coord();
      end
      return q;
   endfunction

   // entered just after a falling edge, returns just after the falling edge following acceptance
   task automatic send_item(req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op          <= it.op;
      req_pos_x       <= it.pos_x;
      req_pos_y       <= it.pos_y;
      req_pos_z       <= it.pos_z;
      req_len_x       <= it.len_x;
      req_len_y       <= it.len_y;
      req_len_z       <= it.len_z;
      req_kind        <= it.kind;
      req_free_width  <= it.free_width;
      req_free_height <= it.free_height;
      req_free_depth  <= it.free_depth;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
      if (it.op == pev_pkg::OP_CLEAR)
         placed.delete();
      else if (it.op == pev_pkg::OP_APPEND && placed.size() < pev_pkg::MAX_BOXES)
         placed.push_back('{it.pos_x, it.pos_y, it.pos_z, it.len_x, it.len_y, it.len_z});
      if (it.op != pev_pkg::OP_NONE) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_box(pev_pkg::box_type b);
      send_item(make_item(pev_pkg::OP_APPEND, b.x0, b.y0, b.z0, b.xl, b.yl, b.zl,
                          2'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord()));
   endtask

   task automatic send_clear();
      send_item(make_item(pev_pkg::OP_CLEAR, any_coord(), any_coord(), any_coord(),
                          any_coord(), any_coord(), any_coord(), 2'($urandom_range(0, 3)),
                          any_coord(), any_coord(), any_coord()));
   endtask

   // result side stalls in bursts, with long quiet stretches in between
   always @(negedge clock) begin
      int r;
      if (stall_left == 0) begin
         r = $urandom_range(0, 9);
         if (r < 5) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(1, 4);
         end else if (r < 8) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 3);
         end else if (r < 9) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 40);
         end else begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(20, 80);
         end
      end else begin
         stall_left = stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_found, rsp_out_len_x, rsp_out_len_y, rsp_out_len_z});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("packing_excluded_volume_finder: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int seq;
      int n;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = pev_pkg::OP_NONE;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pos_z       = '0;
      req_len_x       = '0;
      req_len_y       = '0;
      req_len_z       = '0;
      req_kind        = pev_pkg::KIND_OTHER;
      req_free_width  = '0;
      req_free_height = '0;
      req_free_depth  = '0;
      items_sent      = 0;
      sender_steady   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, each spawn side, zero lengths, extremes, noise op
      send_item(make_item(pev_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, pev_pkg::KIND_RIGHT, 5, 5, 5));
      send_item(make_item(pev_pkg::OP_APPEND, 0, 0, 0, 5, 4, 3, pev_pkg::KIND_RIGHT, 0, 0, 0));
      send_item(make_item(pev_pkg::OP_QUERY, 5, 0, 0, 0, 0, 0, pev_pkg::KIND_RIGHT, 7, 3, 3));
      send_item(make_item(pev_pkg::OP_QUERY, 5, 0, 0, 0, 0, 0, pev_pkg::KIND_RIGHT, 0, 3, 3));
      send_item(make_item(pev_pkg::OP_QUERY, 0, 4, 0, 0, 0, 0, pev_pkg::KIND_TOP, 2, 9, 2));
      send_item(make_item(pev_pkg::OP_QUERY, 1, 4, 0, 0, 0, 0, pev_pkg::KIND_TOP, 2, 9, 2));
      send_item(make_item(pev_pkg::OP_QUERY, 0, 0, 3, 0, 0, 0, pev_pkg::KIND_FRONT, 1, 1, 6));
      send_item(make_item(pev_pkg::OP_QUERY, 5, 0, 0, 0, 0, 0, pev_pkg::KIND_OTHER, 7, 7, 7));
      send_item(make_item(pev_pkg::OP_NONE, '1, '1, '1, '1, '1, '1,
                          pev_pkg::KIND_OTHER, '1, '1, '1));
      send_item(make_item(pev_pkg::OP_APPEND, 5, 0, 0, 2, 4, 3, pev_pkg::KIND_TOP, 0, 0, 0));
      send_item(make_item(pev_pkg::OP_APPEND, 0, 4, 0, 7, 2, 3, pev_pkg::KIND_FRONT, 0, 0, 0));
      send_item(make_item(pev_pkg::OP_QUERY, 5, 4, 0, 0, 0, 0, pev_pkg::KIND_TOP, 4, 4, 4));
      send_item(make_item(pev_pkg::OP_QUERY, 7, 0, 0, 0, 0, 0, pev_pkg::KIND_RIGHT, 9, 9, 9));
      send_item(make_item(pev_pkg::OP_QUERY, 0, 6, 0, 0, 0, 0, pev_pkg::KIND_TOP, 9, 9, 9));
      send_item(make_item(pev_pkg::OP_QUERY, 0, 0, 3, 0, 0, 0, pev_pkg::KIND_FRONT, 9, 9, 9));
      send_item(make_item(pev_pkg::OP_APPEND, '1, '1, '1, '1, '1, '1,
                          pev_pkg::KIND_OTHER, '1, '1, '1));
      send_item(make_item(pev_pkg::OP_APPEND, 0, 0, 0, 0, 0, 0, pev_pkg::KIND_RIGHT, 0, 0, 0));
      send_item(make_item(pev_pkg::OP_QUERY, '1, '1, '1, 0, 0, 0,
                          pev_pkg::KIND_TOP, '1, '1, '1));
      send_item(make_item(pev_pkg::OP_QUERY, '1, '1, '1, 0, 0, 0,
                          pev_pkg::KIND_OTHER, '1, '1, '1));
      send_item(make_item(pev_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, pev_pkg::KIND_RIGHT, 0, 0, 0));
      send_item(make_item(pev_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, pev_pkg::KIND_FRONT, 3, 3, 3));
      send_item(make_item(pev_pkg::OP_APPEND, 0, 0, 0, '1, '1, '1,
                          pev_pkg::KIND_RIGHT, 0, 0, 0));
      send_item(make_item(pev_pkg::OP_QUERY, '1, 0, 0, 0, 0, 0,
                          pev_pkg::KIND_RIGHT, '1, '1, '1));

      // random: fill the store with touching boxes, then query their extreme points
      seq = 0;
      n = items_sent + RANDOM_ITEMS;
      while (items_sent < n) begin
         sender_steady = ($urandom_range(0, 3) == 0);
         if (seq == 2) begin
            // one pass beyond a full store
            send_clear();
            repeat (pev_pkg::MAX_BOXES + 6) send_box(fresh_box());
            repeat (4) send_item(query_item());
         end else begin
            if ($urandom_range(0, 3) != 0 || placed.size() > 40) send_clear();
            repeat ($urandom_range(1, 8)) send_box(fresh_box());
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 9) == 0)
                  send_item(make_item(pev_pkg::OP_NONE, any_coord(), any_coord(),
                                      any_coord(), any_coord(), any_coord(), any_coord(),
                                      2'($urandom_range(0, 3)), any_coord(), any_coord(),
                                      any_coord()));
               else
                  send_item(query_item());
            end
         end
         seq++;
      end
      req_valid <= 1'b0;

      while (sb.pending_volumes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("packing_excluded_volume_finder: match");
      else
         $display("packing_excluded_volume_finder: mismatch");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/pev_pkg.sv
hw/rtl/pev_box_store.sv
hw/rtl/pev_match_unit.sv
hw/rtl/pev_volume_calc.sv
hw/rtl/packing_excluded_volume_finder.sv
verif/tb.sv
